// ----- rtl/scpr_pkg.sv -----
package scpr_pkg;

   localparam int FRAMES_DEFAULT = 16;
   localparam int PAGE_W_DEFAULT = 8;

   localparam int CFG_W   = 5;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 16;

   localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_EVICT,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/second_chance_page_replacement.sv -----
// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_ready  page_number, last_request
// rsp_      out        rsp_valid / rsp_ready  page_fault, frame_slot, evicted_valid,
//                                             evicted_page, fault_count
// csr_      in         csr_valid / csr_ready  frames_in_use
//
// With n active frames a word that hits frame k ends its scan at that frame, a word
// that fills an empty frame scans all n frames, and a word that evicts scans them all
// and then sweeps the hand; the single memory read port and one comparator set this.
// Reset is synchronous; it empties all frames and sets the frame count to four.
// A result that is not taken holds the next word in its final cycle.
module second_chance_page_replacement #(
   parameter int NUM_FRAMES = scpr_pkg::FRAMES_DEFAULT,
   parameter int PAGE_WIDTH = scpr_pkg::PAGE_W_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [PAGE_WIDTH-1:0]        req_page_number,
   input  logic                         req_last_request,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_page_fault,
   output logic [scpr_pkg::SLOT_W-1:0]  rsp_frame_slot,
   output logic                         rsp_evicted_valid,
   output logic [PAGE_WIDTH-1:0]        rsp_evicted_page,
   output logic [scpr_pkg::COUNT_W-1:0] rsp_fault_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [scpr_pkg::CFG_W-1:0]   csr_frames_in_use
);
   import scpr_pkg::*;

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]      frames_cfg_ff;
   logic [CNT_W-1:0]      n_active;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [PAGE_WIDTH-1:0] page_ff, page_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]      empty_idx_ff, empty_idx_in;
   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [PAGE_WIDTH-1:0] old_page_ff, old_page_in;
   logic [IDX_W-1:0]      hand_ff, hand_in;
   logic [COUNT_W-1:0]    faults_ff, faults_in;
   logic                  frame_valid_ff [NUM_FRAMES];
   logic                  frame_valid_in [NUM_FRAMES];
   logic                  ref_ff [NUM_FRAMES];
   logic                  ref_in [NUM_FRAMES];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fault_ff, rsp_fault_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_evict_ff, rsp_evict_in;
   logic [PAGE_WIDTH-1:0] rsp_old_ff, rsp_old_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [PAGE_WIDTH-1:0] frame_mem [NUM_FRAMES];
   logic [PAGE_WIDTH-1:0] rd_data_ff;
   logic                  mem_re;
   logic [IDX_W-1:0]      mem_raddr;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;

   logic                  req_fire;
   logic                  scan_issue;
   logic                  scan_match;
   logic                  scan_last;
   logic                  empty_now;
   logic [IDX_W-1:0]      empty_sel;
   logic                  hand_out;
   logic [IDX_W-1:0]      hand_norm;
   logic [IDX_W-1:0]      hand_next;
   logic                  rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (frames_cfg_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (32'(frames_cfg_ff) > NUM_FRAMES) begin
         n_active = CNT_W'(NUM_FRAMES);
      end else begin
         n_active = CNT_W'(frames_cfg_ff);
      end
   end

   // The comparator and the hand logic are the shared unit of the sequencer.
   always_comb begin
      scan_issue = (scan_cnt_ff < n_ff);
      scan_match = cmp_valid_ff && frame_valid_ff[cmp_idx_ff] && (rd_data_ff == page_ff);
      scan_last  = cmp_valid_ff && ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == n_ff);
      empty_now  = empty_found_ff || (cmp_valid_ff && !frame_valid_ff[cmp_idx_ff]);
      empty_sel  = empty_found_ff ? empty_idx_ff : cmp_idx_ff;
      hand_out   = (CNT_W'(hand_ff) >= n_ff);
      hand_norm  = hand_out ? '0 : hand_ff;
      hand_next  = ((CNT_W'(hand_ff) + CNT_W'(1)) == n_ff) ? '0 : hand_ff + IDX_W'(1);
      rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_match) begin
               state_in = ST_FINISH;
            end else if (scan_last) begin
               state_in = empty_now ? ST_FINISH : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (!ref_ff[hand_ff]) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      n_in           = n_ff;
      page_in        = page_ff;
      last_in        = last_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      hit_in         = hit_ff;
      evict_in       = evict_ff;
      slot_in        = slot_ff;
      old_page_in    = old_page_ff;
      hand_in        = hand_ff;
      faults_in      = faults_ff;
      frame_valid_in = frame_valid_ff;
      ref_in         = ref_ff;
      mem_re         = 1'b0;
      mem_raddr      = hand_ff;
      mem_we         = 1'b0;
      mem_waddr      = hand_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_fault_in   = rsp_fault_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_evict_in   = rsp_evict_ff;
      rsp_old_in     = rsp_old_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in           = n_active;
               page_in        = req_page_number;
               last_in        = req_last_request;
               scan_cnt_in    = '0;
               empty_found_in = 1'b0;
               hit_in         = 1'b0;
               evict_in       = 1'b0;
               old_page_in    = '0;
            end
         end
         ST_SCAN: begin
            if (scan_issue && !scan_match && !scan_last) begin
               mem_re       = 1'b1;
               mem_raddr    = scan_cnt_ff[IDX_W-1:0];
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in  = scan_cnt_ff + CNT_W'(1);
            end
            if (cmp_valid_ff && !frame_valid_ff[cmp_idx_ff] && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_idx_in   = cmp_idx_ff;
            end
            if (scan_match) begin
               hit_in             = 1'b1;
               slot_in            = cmp_idx_ff;
               ref_in[cmp_idx_ff] = 1'b1;
            end else if (scan_last) begin
               if (empty_now) begin
                  slot_in                   = empty_sel;
                  mem_we                    = 1'b1;
                  mem_waddr                 = empty_sel;
                  frame_valid_in[empty_sel] = 1'b1;
                  ref_in[empty_sel]         = 1'b1;
               end else begin
                  hand_in = hand_norm;
               end
            end
         end
         ST_SWEEP: begin
            mem_re    = 1'b1;
            mem_raddr = hand_ff;
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
               hand_in         = hand_next;
            end else begin
               slot_in = hand_ff;
            end
         end
         ST_EVICT: begin
            evict_in        = 1'b1;
            old_page_in     = rd_data_ff;
            mem_we          = 1'b1;
            mem_waddr       = hand_ff;
            ref_in[hand_ff] = 1'b1;
            hand_in         = hand_next;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               if (!hit_ff && (faults_ff != '1)) begin
                  faults_in = faults_ff + COUNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_fault_in = !hit_ff;
               rsp_slot_in  = SLOT_W'(slot_ff);
               rsp_evict_in = evict_ff;
               rsp_old_in   = old_page_ff;
               rsp_count_in = faults_in;
               if (last_ff) begin
                  for (int i = 0; i < NUM_FRAMES; i++) begin
                     frame_valid_in[i] = 1'b0;
                     ref_in[i]         = 1'b0;
                  end
                  hand_in   = '0;
                  faults_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frames_cfg_ff  <= FRAMES_RESET;
         hand_ff        <= '0;
         faults_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_valid_ff[i] <= 1'b0;
            ref_ff[i]         <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         hand_ff        <= hand_in;
         faults_ff      <= faults_in;
         rsp_valid_ff   <= rsp_valid_in;
         cmp_valid_ff   <= cmp_valid_in;
         frame_valid_ff <= frame_valid_in;
         ref_ff         <= ref_in;
         if (csr_valid && csr_ready) begin
            frames_cfg_ff <= csr_frames_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      page_ff        <= page_in;
      last_ff        <= last_in;
      scan_cnt_ff    <= scan_cnt_in;
      cmp_idx_ff     <= cmp_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      hit_ff         <= hit_in;
      evict_ff       <= evict_in;
      slot_ff        <= slot_in;
      old_page_ff    <= old_page_in;
      rsp_fault_ff   <= rsp_fault_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_evict_ff   <= rsp_evict_in;
      rsp_old_ff     <= rsp_old_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= page_ff;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_page_fault    = rsp_fault_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_evicted_page  = rsp_old_ff;
   assign rsp_fault_count   = rsp_count_ff;

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a frame scan");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   a_hand_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) || (state_ff == ST_EVICT)) |-> (CNT_W'(hand_ff) < n_ff))
      else $error("clock hand outside the active frames");

   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_evict_ff || rsp_fault_ff))
      else $error("eviction reported without a page fault");

   a_victim_unreferenced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) |-> (frame_valid_ff[hand_ff] && !ref_ff[hand_ff]))
      else $error("victim frame is empty or still referenced");

endmodule

// ----- bench/tb_second_chance_page_replacement.sv -----
module tb_second_chance_page_replacement;
   timeunit 1ns;
   timeprecision 1ps;

   import scpr_pkg::*;

   localparam int NUM_SLOTS = FRAMES_DEFAULT;
   localparam int PAGE_BITS = PAGE_W_DEFAULT;
   localparam int FAULT_LIMIT = 65535;

   typedef struct packed {
      logic                 page_fault;
      logic [SLOT_W-1:0]    frame_slot;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic [COUNT_W-1:0]   fault_count;
   } page_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic                 req_last_request = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_page_fault;
   logic [SLOT_W-1:0]    rsp_frame_slot;
   logic                 rsp_evicted_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic [COUNT_W-1:0]   rsp_fault_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_frames_in_use = '0;

   // Predicted block state.
   logic [CFG_W-1:0]     frames_setting;
   logic [PAGE_BITS-1:0] frame_page_copy [NUM_SLOTS];
   bit                   frame_used [NUM_SLOTS];
   bit                   ref_bit [NUM_SLOTS];
   int                   hand;
   int                   fault_tally;

   page_result_type      pending_results [$];
   int                   failures = 0;
   int                   items_sent = 0;
   bit                   gaps_on = 1'b0;
   bit                   stall_on = 1'b0;
   int                   hold_request = 0;

   second_chance_page_replacement u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .req_last_request  (req_last_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_frames();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         frame_page_copy[i] = '0;
         frame_used[i] = 1'b0;
         ref_bit[i] = 1'b0;
      end
      hand = 0;
      fault_tally = 0;
   endfunction

   function automatic void predict_reference(input logic [PAGE_BITS-1:0] page,
                                             input logic last);
      int active;
      int slot;
      int i;
      bit hit;
      bit placed;
      page_result_type want;
      active = int'(frames_setting);
      if (active == 0) active = 1;
      if (active > NUM_SLOTS) active = NUM_SLOTS;
      hit = 1'b0;
      placed = 1'b0;
      slot = 0;
      want = '0;
      for (i = 0; i < active && !hit; i++) begin
         if (frame_used[i] && frame_page_copy[i] == page) begin
            hit = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         ref_bit[slot] = 1'b1;
      end else begin
         for (i = 0; i < active && !placed; i++) begin
            if (!frame_used[i]) begin
               placed = 1'b1;
               slot = i;
            end
         end
         if (placed) begin
            frame_page_copy[slot] = page;
            frame_used[slot] = 1'b1;
            ref_bit[slot] = 1'b1;
         end else begin
            if (hand >= active) hand = 0;
            for (i = 0; i <= active && ref_bit[hand]; i++) begin
               ref_bit[hand] = 1'b0;
               hand = (hand + 1 < active) ? hand + 1 : 0;
            end
            slot = hand;
            want.evicted_valid = 1'b1;
            want.evicted_page = frame_page_copy[slot];
            frame_page_copy[slot] = page;
            ref_bit[slot] = 1'b1;
            hand = (hand + 1 < active) ? hand + 1 : 0;
         end
         if (fault_tally < FAULT_LIMIT) fault_tally++;
      end
      want.page_fault = !hit;
      want.frame_slot = SLOT_W'(slot);
      want.fault_count = COUNT_W'(fault_tally);
      pending_results.push_back(want);
      if (last) clear_frames();
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      page_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            failures++;
            $error("result word with no reference outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("page_fault", want.page_fault, rsp_page_fault);
            check_field("frame_slot", want.frame_slot, rsp_frame_slot);
            check_field("evicted_valid", want.evicted_valid, rsp_evicted_valid);
            check_field("evicted_page", want.evicted_page, rsp_evicted_page);
            check_field("fault_count", want.fault_count, rsp_fault_count);
         end
      end
   end

   // Result side: random stall bursts, plus a long hold-off on request.
   initial begin : result_side
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_ready <= 1'b1;
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic last);
      req_valid <= 1'b1;
      req_page_number <= page;
      req_last_request <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_reference(page, last);
      items_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [CFG_W-1:0] value);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      frames_setting = value;
   endtask

   task automatic test_basic_replacement();
      gaps_on = 1'b1;
      stall_on = 1'b1;
      // Default of four frames: fill, hit, then three evictions, two of them after sweeps.
      send_reference(8'd0, 1'b0);
      send_reference(8'd255, 1'b0);
      send_reference(8'd0, 1'b0);
      send_reference(8'd7, 1'b0);
      send_reference(8'd9, 1'b0);
      send_reference(8'd128, 1'b0);
      send_reference(8'd255, 1'b0);
      send_reference(8'd64, 1'b0);
      send_reference(8'd255, 1'b0);
      send_reference(8'd200, 1'b1);
      send_reference(8'd255, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_frame_count_edges();
      // A count of zero behaves as a single frame.
      write_frame_count(5'd0);
      send_reference(8'd5, 1'b0);
      send_reference(8'd5, 1'b0);
      send_reference(8'd6, 1'b1);
      // Counts above the built frame count saturate.
      write_frame_count(5'd31);
      send_reference(8'd3, 1'b0);
      send_reference(8'd4, 1'b1);
      write_frame_count(5'd16);
      // Shrink and regrow mid-sequence so a page sits in two frames.
      write_frame_count(5'd4);
      send_reference(8'd10, 1'b0);
      send_reference(8'd11, 1'b0);
      send_reference(8'd12, 1'b0);
      send_reference(8'd13, 1'b0);
      send_reference(8'd20, 1'b0);
      send_reference(8'd21, 1'b0);
      send_reference(8'd22, 1'b0);
      write_frame_count(5'd2);
      send_reference(8'd13, 1'b0);
      write_frame_count(5'd4);
      send_reference(8'd13, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_sequences();
      int target;
      int run_length;
      int working_set;
      int base;
      logic [PAGE_BITS-1:0] page;
      logic last;
      target = items_sent + 1600;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) < 7) write_frame_count(CFG_W'($urandom_range(1, 16)));
         else write_frame_count(CFG_W'($urandom_range(0, 31)));
         gaps_on = ($urandom_range(0, 2) != 0);
         stall_on = ($urandom_range(0, 2) != 0);
         run_length = $urandom_range(1, 80);
         working_set = $urandom_range(1, 24);
         base = $urandom_range(0, 255);
         for (int k = 0; k < run_length; k++) begin
            if ($urandom_range(0, 9) == 0) page = PAGE_BITS'($urandom_range(0, 255));
            else page = PAGE_BITS'(base + $urandom_range(0, working_set - 1));
            if (k == run_length - 1) last = ($urandom_range(0, 3) != 0);
            else last = ($urandom_range(0, 49) == 0);
            send_reference(page, last);
         end
      end
      wait_for_drain();
   endtask

   task automatic test_result_backpressure();
      write_frame_count(5'd8);
      gaps_on = 1'b0;
      stall_on = 1'b0;
      hold_request = 300;
      for (int k = 0; k < 24; k++)
         send_reference(PAGE_BITS'($urandom_range(0, 15)), k == 23);
      wait_for_drain();
   endtask

   task automatic test_every_reference_faults();
      logic [PAGE_BITS-1:0] page_a;
      logic [PAGE_BITS-1:0] page_b;
      page_a = PAGE_BITS'($urandom_range(0, 127));
      page_b = PAGE_BITS'($urandom_range(128, 255));
      gaps_on = 1'b0;
      stall_on = 1'b0;
      // One frame and two alternating pages: every reference is a fault.
      write_frame_count(5'd1);
      for (int k = 0; k < 40; k++)
         send_reference(k[0] ? page_b : page_a, k == 39);
      wait_for_drain();
   endtask

   initial begin
      frames_setting = FRAMES_RESET;
      clear_frames();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_replacement();
      test_frame_count_edges();
      test_random_sequences();
      test_result_backpressure();
      test_every_reference_faults();
      repeat (2 * NUM_SLOTS + 8) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/scpr_pkg.sv
rtl/second_chance_page_replacement.sv
bench/tb_second_chance_page_replacement.sv
